// ===== design/pis_pkg.sv =====
// Shared constants, widths and types for the pairwise force pipeline.
`timescale 1ns / 1ps
package pis_pkg;

  // Field widths and fixed-point format
  localparam int CW = 32;            // coordinate width
  localparam int FB = 12;            // fraction bits
  localparam int OW = 32;            // force component width
  localparam int KW = 32;            // strength register width
  localparam int MW = 31;            // cutoff register width

  // Usable difference magnitude; anything at or above 2^UW is out of range
  localparam int UW = OW - 1;
  // Squared distance width
  localparam int SW = 2 * UW + 1;
  // Strength numerator K << 2*FB
  localparam int NW = KW + 2 * FB;
  // Square root rounds and distance width
  localparam int ROUNDS = (SW + 1) / 2;
  localparam int DW = ROUNDS;
  // Magnitude times component product
  localparam int PW = NW + UW;
  localparam int HALF = NW / 2;

  // Minimum distance in raw units, and its square
  localparam longint MIN_DIST = (64'd1 << FB) / 1000;
  localparam longint MIN_SQ = MIN_DIST * MIN_DIST;

  // Configuration register indexes
  localparam logic [1:0] REG_STRENGTH = 2'd0;
  localparam logic [1:0] REG_MAX_DIST = 2'd1;
  localparam logic [1:0] REG_ATTRACT  = 2'd2;

  typedef struct packed {
    logic [KW-1:0] strength;
    logic [MW-1:0] max_dist;
    logic          attract;
  } cfg_t;

  // Per-request geometry carried down the pipe
  typedef struct packed {
    logic [UW-1:0] ux;
    logic [UW-1:0] uy;
    logic          nx;   // x force negative
    logic          ny;   // y force negative
    logic          ok;   // distance within range
  } geo_t;

endpackage

// ===== design/pairwise_inverse_square_force.sv =====
// Top level of the pairwise inverse-square force pipeline with cutoff.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_a_x, in_a_y, in_b_x, in_b_y
//   out      output     out_valid/out_stall out_force_x, out_force_y, out_applied,
//                                          out_saturated
//   cfg      input      cfg_we             cfg_index, cfg_data
//
// One request enters per cycle unless the output stalls. The path holds 3 front stages, 56 stages
// of the magnitude divider (which also run the 32 square root rounds), 3 multiply and seed
// stages, 32 stages of the distance divider and the output register.
// Reset is synchronous, active low, clears all valid bits, strength and cutoff, and sets attract.
// A stalled result freezes the whole pipe; in_stall rises only while a result is held.
`timescale 1ns / 1ps
module pairwise_inverse_square_force (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [pis_pkg::CW-1:0] in_a_x,
  input  logic signed [pis_pkg::CW-1:0] in_a_y,
  input  logic signed [pis_pkg::CW-1:0] in_b_x,
  input  logic signed [pis_pkg::CW-1:0] in_b_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [pis_pkg::OW-1:0] out_force_x,
  output logic signed [pis_pkg::OW-1:0] out_force_y,
  output logic                         out_applied,
  output logic                         out_saturated,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [pis_pkg::KW-1:0]       cfg_data
);
  import pis_pkg::*;

  cfg_t          cfg_r;
  logic          en;
  logic          fv, cv;
  geo_t          fg, cg;
  logic [SW-1:0] fs;
  logic [NW-1:0] cmag;
  logic [DW-1:0] cdist;
  logic [OW-1:0] fx, fy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strength <= '0;
      cfg_r.max_dist <= '0;
      cfg_r.attract  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRENGTH: cfg_r.strength <= cfg_data;
        REG_MAX_DIST: cfg_r.max_dist <= cfg_data[MW-1:0];
        REG_ATTRACT:  cfg_r.attract  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance unless a finished result is held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  pis_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .a_x       (in_a_x),
    .a_y       (in_a_y),
    .b_x       (in_b_x),
    .b_y       (in_b_y),
    .cfg       (cfg_r),
    .out_valid (fv),
    .out_geo   (fg),
    .out_s     (fs)
  );

  pis_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv),
    .in_geo    (fg),
    .in_s      (fs),
    .strength  (cfg_r.strength),
    .out_valid (cv),
    .out_geo   (cg),
    .out_mag   (cmag),
    .out_dist  (cdist)
  );

  pis_comp u_comp (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (cv),
    .in_geo        (cg),
    .in_mag        (cmag),
    .in_dist       (cdist),
    .out_valid     (out_valid),
    .out_force_x   (fx),
    .out_force_y   (fy),
    .out_applied   (out_applied),
    .out_saturated (out_saturated)
  );

  assign out_force_x = $signed(fx);
  assign out_force_y = $signed(fy);

endmodule

// ===== design/pis_front.sv =====
// Front stages: difference vector, squares, squared distance and range check.
`timescale 1ns / 1ps
module pis_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [pis_pkg::CW-1:0] a_x,
  input  logic signed [pis_pkg::CW-1:0] a_y,
  input  logic signed [pis_pkg::CW-1:0] b_x,
  input  logic signed [pis_pkg::CW-1:0] b_y,
  input  pis_pkg::cfg_t            cfg,
  output logic                     out_valid,
  output pis_pkg::geo_t            out_geo,
  output logic [pis_pkg::SW-1:0]   out_s
);
  import pis_pkg::*;

  logic [CW:0] dx, dy, ax, ay;

  logic          v1_r, v2_r, v3_r;
  logic [UW-1:0] ux1_r, uy1_r;
  logic          nx1_r, ny1_r, far1_r;
  logic [UW-1:0] ux2_r, uy2_r;
  logic          nx2_r, ny2_r, far2_r;
  logic [SW-2:0] sqx2_r, sqy2_r, mm2_r;
  logic [SW-1:0] s_nxt, s3_r;
  geo_t          g3_r;
  logic          ok_nxt;

  // Difference and magnitude
  always_comb begin
    dx = {b_x[CW-1], b_x} - {a_x[CW-1], a_x};
    dy = {b_y[CW-1], b_y} - {a_y[CW-1], a_y};
    ax = dx[CW] ? ((CW+1)'(0) - dx) : dx;
    ay = dy[CW] ? ((CW+1)'(0) - dy) : dy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux1_r  <= ax[UW-1:0];
      uy1_r  <= ay[UW-1:0];
      nx1_r  <= dx[CW] ^ ~cfg.attract;
      ny1_r  <= dy[CW] ^ ~cfg.attract;
      far1_r <= (|ax[CW:UW]) | (|ay[CW:UW]);
    end
  end

  // Squares of both components and of the cutoff
  always_ff @(posedge clk) begin
    if (en) begin
      sqx2_r <= ux1_r * ux1_r;
      sqy2_r <= uy1_r * uy1_r;
      mm2_r  <= cfg.max_dist * cfg.max_dist;
      ux2_r  <= ux1_r;
      uy2_r  <= uy1_r;
      nx2_r  <= nx1_r;
      ny2_r  <= ny1_r;
      far2_r <= far1_r;
    end
  end

  // Sum and range check
  always_comb begin
    s_nxt  = {1'b0, sqx2_r} + {1'b0, sqy2_r};
    ok_nxt = !far2_r && (s_nxt > SW'(MIN_SQ)) && (s_nxt < {1'b0, mm2_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r     <= s_nxt;
      g3_r.ux  <= ux2_r;
      g3_r.uy  <= uy2_r;
      g3_r.nx  <= nx2_r;
      g3_r.ny  <= ny2_r;
      g3_r.ok  <= ok_nxt;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_geo   = g3_r;
  assign out_s     = s3_r;

endmodule

// ===== design/pis_core.sv =====
// Core stages: magnitude division K*2^(2F)/S and integer square root, one step per stage.
`timescale 1ns / 1ps
module pis_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  pis_pkg::geo_t          in_geo,
  input  logic [pis_pkg::SW-1:0] in_s,
  input  logic [pis_pkg::KW-1:0] strength,
  output logic                   out_valid,
  output pis_pkg::geo_t          out_geo,
  output logic [pis_pkg::NW-1:0] out_mag,
  output logic [pis_pkg::DW-1:0] out_dist
);
  import pis_pkg::*;

  typedef struct packed {
    geo_t          g;
    logic [SW-1:0] s;
    logic [SW-1:0] rem;
    logic [NW-1:0] q;
    logic [SW-1:0] sr;
    logic [SW-1:0] root;
  } core_t;

  core_t head;
  core_t stg_r [1:NW];
  logic  v_r   [1:NW];

  always_comb begin
    head.g    = in_geo;
    head.s    = in_s;
    head.rem  = '0;
    head.q    = '0;
    head.sr   = in_s;
    head.root = '0;
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    core_t         src, nxt;
    logic          src_v, nbit;
    logic [SW:0]   trial;
    logic [SW-1:0] sr_n, root_n;

    if (k == 0) begin : g_first
      assign src   = head;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = stg_r[k];
      assign src_v = v_r[k];
    end

    // Next numerator bit, strength then zero fraction
    if (k < KW) begin : g_nb
      assign nbit = strength[KW-1-k];
    end else begin : g_nz
      assign nbit = 1'b0;
    end

    // Square root round while rounds remain
    if (k < ROUNDS) begin : g_sq
      localparam logic [SW:0] BIT = (SW+1)'(1) << (2 * (ROUNDS - 1 - k));
      logic [SW:0] t;
      always_comb begin
        t = {1'b0, src.root} + BIT;
        if ({1'b0, src.sr} >= t) begin
          sr_n   = SW'({1'b0, src.sr} - t);
          root_n = SW'(({1'b0, src.root} >> 1) + BIT);
        end else begin
          sr_n   = src.sr;
          root_n = src.root >> 1;
        end
      end
    end else begin : g_nosq
      assign sr_n   = src.sr;
      assign root_n = src.root;
    end

    // Restoring division step
    always_comb begin
      nxt   = src;
      trial = {src.rem, nbit};
      if (trial >= {1'b0, src.s}) begin
        nxt.rem = SW'(trial - {1'b0, src.s});
        nxt.q   = {src.q[NW-2:0], 1'b1};
      end else begin
        nxt.rem = trial[SW-1:0];
        nxt.q   = {src.q[NW-2:0], 1'b0};
      end
      nxt.sr   = sr_n;
      nxt.root = root_n;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k+1] <= nxt;
      end
    end
  end

  assign out_valid = v_r[NW];
  assign out_geo   = stg_r[NW].g;
  assign out_mag   = stg_r[NW].q;
  assign out_dist  = stg_r[NW].root[DW-1:0];

endmodule

// ===== design/pis_comp.sv =====
// Component stages: split multiply, division by distance, saturation and output register.
`timescale 1ns / 1ps
module pis_comp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  pis_pkg::geo_t          in_geo,
  input  logic [pis_pkg::NW-1:0] in_mag,
  input  logic [pis_pkg::DW-1:0] in_dist,
  output logic                   out_valid,
  output logic [pis_pkg::OW-1:0] out_force_x,
  output logic [pis_pkg::OW-1:0] out_force_y,
  output logic                   out_applied,
  output logic                   out_saturated
);
  import pis_pkg::*;

  localparam int HW = NW - HALF;
  localparam logic [OW-1:0] LIM_POS = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] LIM_NEG = {1'b1, {(OW-1){1'b0}}};

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] low;
    logic [DW-1:0] q;
    logic          ovf;
  } cdiv_t;

  typedef struct packed {
    geo_t          g;
    logic [DW-1:0] dlen;
    cdiv_t         x;
    cdiv_t         y;
  } cstg_t;

  function automatic cdiv_t div_step(cdiv_t a, logic [DW-1:0] d);
    logic [DW:0] t;
    cdiv_t       r;
    r     = a;
    t     = {a.rem, a.low[DW-1]};
    r.low = {a.low[DW-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem = DW'(t - {1'b0, d});
      r.q   = {a.q[DW-2:0], 1'b1};
    end else begin
      r.rem = t[DW-1:0];
      r.q   = {a.q[DW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic cdiv_t div_init(logic [PW-1:0] p, logic [DW-1:0] d);
    cdiv_t r;
    r.ovf = p[PW-1:DW] >= (PW-DW)'(d);
    r.rem = p[2*DW-1:DW];
    r.low = p[DW-1:0];
    r.q   = '0;
    return r;
  endfunction

  logic              v1_r, v2_r, out_valid_r;
  geo_t              g1_r, g2_r;
  logic [DW-1:0]     d1_r, d2_r;
  logic [HALF+UW-1:0] plx1_r, ply1_r;
  logic [HW+UW-1:0]  phx1_r, phy1_r;
  logic [PW-1:0]     px2_r, py2_r;
  cstg_t             stg_r [0:DW];
  logic              v_r   [0:DW];

  // Split products of magnitude and each component
  always_ff @(posedge clk) begin
    if (en) begin
      plx1_r <= in_mag[HALF-1:0] * in_geo.ux;
      phx1_r <= in_mag[NW-1:HALF] * in_geo.ux;
      ply1_r <= in_mag[HALF-1:0] * in_geo.uy;
      phy1_r <= in_mag[NW-1:HALF] * in_geo.uy;
      g1_r   <= in_geo;
      d1_r   <= in_dist;
    end
  end

  // Merge partial products
  always_ff @(posedge clk) begin
    if (en) begin
      px2_r <= PW'({phx1_r, {HALF{1'b0}}}) + PW'(plx1_r);
      py2_r <= PW'({phy1_r, {HALF{1'b0}}}) + PW'(ply1_r);
      g2_r  <= g1_r;
      d2_r  <= d1_r;
    end
  end

  // Check quotient overflow and seed remainders
  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0].g    <= g2_r;
      stg_r[0].dlen <= d2_r;
      stg_r[0].x    <= div_init(px2_r, d2_r);
      stg_r[0].y    <= div_init(py2_r, d2_r);
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k+1].g    <= stg_r[k].g;
        stg_r[k+1].dlen <= stg_r[k].dlen;
        stg_r[k+1].x    <= div_step(stg_r[k].x, stg_r[k].dlen);
        stg_r[k+1].y    <= div_step(stg_r[k].y, stg_r[k].dlen);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  // Clamp, apply sign, hold result
  cstg_t         last;
  logic [OW-1:0] limx, limy, mx, my, fx_nxt, fy_nxt;
  logic          satx, saty;

  always_comb begin
    last   = stg_r[DW];
    limx   = last.g.nx ? LIM_NEG : LIM_POS;
    limy   = last.g.ny ? LIM_NEG : LIM_POS;
    satx   = last.x.ovf || ((DW+OW)'(last.x.q) > (DW+OW)'(limx));
    saty   = last.y.ovf || ((DW+OW)'(last.y.q) > (DW+OW)'(limy));
    mx     = satx ? limx : OW'(last.x.q);
    my     = saty ? limy : OW'(last.y.q);
    fx_nxt = last.g.nx ? (OW'(0) - mx) : mx;
    fy_nxt = last.g.ny ? (OW'(0) - my) : my;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_force_x   <= last.g.ok ? fx_nxt : '0;
      out_force_y   <= last.g.ok ? fy_nxt : '0;
      out_applied   <= last.g.ok;
      out_saturated <= last.g.ok && (satx || saty);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v_r[0]      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v_r[0]      <= v2_r;
      out_valid_r <= v_r[DW];
    end
  end

  assign out_valid = out_valid_r;

endmodule
